@@ design/rscr_pkg.sv @@
package rscr_pkg;

  // Default store depth
  localparam int unsigned MaxRecordsDef = 16;

  // Field widths
  localparam int unsigned IdW    = 16;
  localparam int unsigned ScoreW = 8;
  localparam int unsigned SumW   = 10;
  localparam int unsigned PlaceW = 5;

  // One stored record
  typedef struct packed {
    logic [IdW-1:0]    id;
    logic [ScoreW-1:0] a;
    logic [ScoreW-1:0] b;
    logic [ScoreW-1:0] c;
    logic [SumW-1:0]   sum;
  } rec_t;

  // Controller states
  typedef enum logic [2:0] {
    StIdle,
    StScan,
    StTail,
    StLoad,
    StEmit
  } state_e;

  // Commands from controller to datapath
  typedef struct packed {
    logic store;
    logic pass_start;
    logic rd;
    logic load;
    logic clear;
  } ctrl_t;

  // Status from datapath to controller
  typedef struct packed {
    logic scan_end;
    logic run_done;
  } stat_t;

endpackage

@@ design/rscr_in_if.sv @@
interface rscr_in_if;
  logic                       valid;
  logic                       ready;
  logic [rscr_pkg::IdW-1:0]    record_id;
  logic [rscr_pkg::ScoreW-1:0] score_a;
  logic [rscr_pkg::ScoreW-1:0] score_b;
  logic [rscr_pkg::ScoreW-1:0] score_c;
  logic                       last;

  modport source (output valid, record_id, score_a, score_b, score_c, last, input ready);
  modport sink   (input valid, record_id, score_a, score_b, score_c, last, output ready);
endinterface

@@ design/rscr_out_if.sv @@
interface rscr_out_if;
  logic                       valid;
  logic                       ready;
  logic [rscr_pkg::PlaceW-1:0] place;
  logic [rscr_pkg::IdW-1:0]    out_id;
  logic [rscr_pkg::ScoreW-1:0] out_a;
  logic [rscr_pkg::ScoreW-1:0] out_b;
  logic [rscr_pkg::ScoreW-1:0] out_c;
  logic                       overflow;
  logic                       final_res;

  modport source (output valid, place, out_id, out_a, out_b, out_c, overflow, final_res,
                  input ready);
  modport sink   (input valid, place, out_id, out_a, out_b, out_c, overflow, final_res,
                  output ready);
endinterface

@@ design/rscr_ctrl.sv @@
module rscr_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  input  logic            in_last_i,
  input  logic            out_ready_i,
  input  rscr_pkg::stat_t stat_i,
  output rscr_pkg::ctrl_t cmd_o,
  output logic            in_ready_o,
  output logic            out_valid_o
);

  rscr_pkg::state_e state_q, state_d;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= rscr_pkg::StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      rscr_pkg::StIdle: begin
        if (in_valid_i && in_last_i) state_d = rscr_pkg::StScan;
      end
      rscr_pkg::StScan: begin
        if (stat_i.scan_end) state_d = rscr_pkg::StTail;
      end
      rscr_pkg::StTail: state_d = rscr_pkg::StLoad;
      rscr_pkg::StLoad: state_d = rscr_pkg::StEmit;
      rscr_pkg::StEmit: begin
        if (out_ready_i) begin
          state_d = stat_i.run_done ? rscr_pkg::StIdle : rscr_pkg::StScan;
        end
      end
      default: state_d = rscr_pkg::StIdle;
    endcase
  end

  // Outputs and commands
  always_comb begin
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    unique case (state_q)
      rscr_pkg::StIdle: begin
        in_ready_o       = 1'b1;
        cmd_o.store      = in_valid_i;
        cmd_o.pass_start = in_valid_i && in_last_i;
      end
      rscr_pkg::StScan: cmd_o.rd = 1'b1;
      rscr_pkg::StTail: ;
      rscr_pkg::StLoad: cmd_o.load = 1'b1;
      rscr_pkg::StEmit: begin
        out_valid_o      = 1'b1;
        cmd_o.clear      = out_ready_i && stat_i.run_done;
        cmd_o.pass_start = out_ready_i && !stat_i.run_done;
      end
      default: ;
    endcase
  end

endmodule

@@ design/rscr_dpath.sv @@
module rscr_dpath #(
  parameter int unsigned MAX_RECORDS = rscr_pkg::MaxRecordsDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  rscr_pkg::ctrl_t              cmd_i,
  input  logic [rscr_pkg::IdW-1:0]     record_id_i,
  input  logic [rscr_pkg::ScoreW-1:0]  score_a_i,
  input  logic [rscr_pkg::ScoreW-1:0]  score_b_i,
  input  logic [rscr_pkg::ScoreW-1:0]  score_c_i,
  output rscr_pkg::stat_t              stat_o,
  output logic [rscr_pkg::PlaceW-1:0]  place_o,
  output logic [rscr_pkg::IdW-1:0]     out_id_o,
  output logic [rscr_pkg::ScoreW-1:0]  out_a_o,
  output logic [rscr_pkg::ScoreW-1:0]  out_b_o,
  output logic [rscr_pkg::ScoreW-1:0]  out_c_o,
  output logic                         overflow_o,
  output logic                         final_res_o
);

  localparam int unsigned IW = $clog2(MAX_RECORDS);
  localparam int unsigned CW = $clog2(MAX_RECORDS + 1);
  localparam int unsigned KW = rscr_pkg::SumW + rscr_pkg::IdW + IW;

  // Record store, arrival order
  rscr_pkg::rec_t mem [MAX_RECORDS];

  logic [CW-1:0]  count_q;
  logic           dropped_q;
  logic [IW-1:0]  rd_idx_q;
  logic [IW-1:0]  rd_addr_q;
  logic           rd_vld_q;
  rscr_pkg::rec_t rd_data_q;
  rscr_pkg::rec_t best_q;
  logic [KW-1:0]  best_key_q;
  logic           have_best_q;
  logic [KW-1:0]  prev_key_q;
  logic [rscr_pkg::SumW-1:0] prev_sum_q;
  logic [CW-1:0]  pos_q;
  logic [CW-1:0]  rank_q;
  rscr_pkg::rec_t out_rec_q;
  logic           overflow_q;
  logic           final_q;

  rscr_pkg::rec_t in_rec;
  logic           full;
  logic [KW-1:0]  cand_key;
  logic           after_prev;
  logic           better;
  logic           take;
  logic [CW-1:0]  pos_inc;

  // Incoming word with its score sum
  always_comb begin
    in_rec.id  = record_id_i;
    in_rec.a   = score_a_i;
    in_rec.b   = score_b_i;
    in_rec.c   = score_c_i;
    in_rec.sum = rscr_pkg::SumW'(score_a_i) + rscr_pkg::SumW'(score_b_i)
               + rscr_pkg::SumW'(score_c_i);
  end

  assign full = (count_q == CW'(MAX_RECORDS));

  // Store write and registered read
  always_ff @(posedge clk_i) begin
    if (cmd_i.store && !full) begin
      mem[count_q[IW-1:0]] <= in_rec;
    end
    rd_data_q <= mem[rd_idx_q];
    rd_addr_q <= rd_idx_q;
  end

  // Sort key: smaller goes first (higher sum, then lower id, then arrival)
  assign cand_key   = {~rd_data_q.sum, rd_data_q.id, rd_addr_q};
  assign after_prev = (pos_q == '0) || (cand_key > prev_key_q);
  assign better     = !have_best_q || (cand_key < best_key_q);
  assign take       = rd_vld_q && after_prev && better;
  assign pos_inc    = pos_q + CW'(1);

  // Fill count, drop flag, scan pointer, best-valid flag and output position
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      dropped_q   <= 1'b0;
      rd_idx_q    <= '0;
      rd_vld_q    <= 1'b0;
      have_best_q <= 1'b0;
      pos_q       <= '0;
    end else begin
      rd_vld_q <= cmd_i.rd;
      if (cmd_i.store) begin
        if (!full) count_q <= count_q + CW'(1);
        else       dropped_q <= 1'b1;
      end
      if (cmd_i.pass_start) begin
        rd_idx_q    <= '0;
        have_best_q <= 1'b0;
      end else begin
        if (cmd_i.rd) rd_idx_q <= rd_idx_q + IW'(1);
        if (take)     have_best_q <= 1'b1;
      end
      if (cmd_i.load) pos_q <= pos_inc;
      if (cmd_i.clear) begin
        count_q   <= '0;
        dropped_q <= 1'b0;
        pos_q     <= '0;
      end
    end
  end

  // Best candidate of the pass and result register
  always_ff @(posedge clk_i) begin
    if (take) begin
      best_q     <= rd_data_q;
      best_key_q <= cand_key;
    end
    if (cmd_i.load) begin
      out_rec_q  <= best_q;
      prev_key_q <= best_key_q;
      prev_sum_q <= best_q.sum;
      overflow_q <= dropped_q;
      final_q    <= (pos_inc == count_q);
      // ties keep the rank of the first of the tie
      if (pos_q == '0 || best_q.sum != prev_sum_q) rank_q <= pos_inc;
    end
  end

  assign stat_o.scan_end = (CW'(rd_idx_q) == count_q - CW'(1));
  assign stat_o.run_done = final_q;

  assign place_o     = rscr_pkg::PlaceW'(rank_q);
  assign out_id_o    = out_rec_q.id;
  assign out_a_o     = out_rec_q.a;
  assign out_b_o     = out_rec_q.b;
  assign out_c_o     = out_rec_q.c;
  assign overflow_o  = overflow_q;
  assign final_res_o = final_q;

endmodule

@@ design/record_sort_with_competition_rank.sv @@
// Record sorter with competition ranking.
// in_i takes one word per record (id, three scores, last) whenever the
// block is collecting; each accepted word is stored as it is accepted, so
// records may arrive back to back. Records past MAX_RECORDS are dropped
// and the set is flagged as overflowed.
// A word with last set (stored or dropped) closes the set: in_i.ready
// falls and the stored records leave on out_o, highest score sum first,
// equal sums by ascending id, each with its competition place.
// Each result costs one scan of the store, one memory read per cycle,
// followed by the tail, load and emit states of the controller.
// A stalled result holds on out_o; the next scan starts once it is taken.
// After the word with final_res set is taken, in_i.ready returns the
// next cycle and a new set begins with an empty store.
// Reset empties the store and clears the overflow flag; no clearing
// pass is needed.
module record_sort_with_competition_rank #(
  parameter int unsigned MAX_RECORDS = rscr_pkg::MaxRecordsDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  rscr_in_if.sink    in_i,
  rscr_out_if.source out_o
);

  rscr_pkg::ctrl_t cmd;
  rscr_pkg::stat_t stat;

  // Controller
  rscr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_last_i   (in_i.last),
    .out_ready_i (out_o.ready),
    .stat_i      (stat),
    .cmd_o       (cmd),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid)
  );

  // Datapath
  rscr_dpath #(
    .MAX_RECORDS (MAX_RECORDS)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .record_id_i (in_i.record_id),
    .score_a_i   (in_i.score_a),
    .score_b_i   (in_i.score_b),
    .score_c_i   (in_i.score_c),
    .stat_o      (stat),
    .place_o     (out_o.place),
    .out_id_o    (out_o.out_id),
    .out_a_o     (out_o.out_a),
    .out_b_o     (out_o.out_b),
    .out_c_o     (out_o.out_c),
    .overflow_o  (out_o.overflow),
    .final_res_o (out_o.final_res)
  );

`ifndef ASSERT_OFF
  // Collecting and emitting never overlap
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_i.ready && out_o.valid))
    else $error("input ready while a result is shown");

  // A closing word stops intake
  a_last_stops: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready && in_i.last) |=> !in_i.ready)
    else $error("intake continued after the closing word");

  // Taking the final result reopens intake
  a_final_reopens: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.ready && out_o.final_res) |=> (in_i.ready && !out_o.valid))
    else $error("intake not reopened after the final result");
`endif

endmodule
